/* sv/crc32fa_pkg.sv */
// Shared types, constants and CRC functions for the CRC-32 frame engine.
`default_nettype none

package crc32fa_pkg;

  localparam logic [31:0] CrcPoly    = 32'h04C11DB7;
  localparam int unsigned HoldDepth  = 4;
  localparam int unsigned MaxBurst   = 5;
  localparam int unsigned QueueDepth = MaxBurst + 1;

  typedef enum logic [1:0] {
    StatusGood     = 2'd0,
    StatusMismatch = 2'd1,
    StatusShort    = 2'd2
  } status_e;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_data;
    logic       end_of_frame;
    status_e    frame_status;
  } result_t;

  typedef struct packed {
    logic [2:0]                 count;
    result_t [MaxBurst-1:0]     words;
  } burst_t;

  function automatic logic [31:0] crc_table_entry(input logic [7:0] idx);
    logic [31:0] r;
    r = {idx, 24'h0};
    for (int i = 0; i < 8; i++) begin
      r = r[31] ? ((r << 1) ^ CrcPoly) : (r << 1);
    end
    return r;
  endfunction

  function automatic logic [31:0] crc_update(input logic [31:0] crc, input logic [7:0] b);
    return {crc[23:0], 8'h00} ^ crc_table_entry(crc[31:24] ^ b);
  endfunction

endpackage

`default_nettype wire

/* sv/crc32fa_crc_unit.sv */
// CRC state, holdback line and per-word result burst generation.
`default_nettype none

module crc32fa_crc_unit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  logic [7:0]           data_byte_i,
  input  logic                 last_byte_i,
  input  logic                 direction_i,
  output crc32fa_pkg::burst_t  burst_o
);

  logic [31:0] crc_q, crc_d;
  logic [2:0]  bytes_q, bytes_d;
  logic [7:0]  hold_q [crc32fa_pkg::HoldDepth];
  logic [7:0]  hold_d [crc32fa_pkg::HoldDepth];
  logic [31:0] crc_next;
  logic        full;

  assign crc_next = crc32fa_pkg::crc_update(crc_q, data_byte_i);
  assign full     = bytes_q[2];

  always_comb begin
    crc_d   = crc_q;
    bytes_d = bytes_q;
    hold_d  = hold_q;
    burst_o = '0;
    if (!direction_i) begin
      // Transmit: pass the word through, append the CRC on the last one.
      burst_o.count                = 3'd1;
      burst_o.words[0].out_byte    = data_byte_i;
      burst_o.words[0].has_data    = 1'b1;
      crc_d                        = crc_next;
      if (last_byte_i) begin
        burst_o.count                 = 3'd5;
        burst_o.words[1].out_byte     = crc_next[31:24];
        burst_o.words[1].has_data     = 1'b1;
        burst_o.words[2].out_byte     = crc_next[23:16];
        burst_o.words[2].has_data     = 1'b1;
        burst_o.words[3].out_byte     = crc_next[15:8];
        burst_o.words[3].has_data     = 1'b1;
        burst_o.words[4].out_byte     = crc_next[7:0];
        burst_o.words[4].has_data     = 1'b1;
        burst_o.words[4].end_of_frame = 1'b1;
        crc_d                         = '0;
        bytes_d                       = '0;
      end
    end else begin
      // Receive: hold back the newest four bytes, release the oldest.
      crc_d = crc_next;
      if (full) begin
        burst_o.count             = 3'd1;
        burst_o.words[0].out_byte = hold_q[0];
        burst_o.words[0].has_data = 1'b1;
        hold_d[0] = hold_q[1];
        hold_d[1] = hold_q[2];
        hold_d[2] = hold_q[3];
        hold_d[3] = data_byte_i;
      end else begin
        hold_d[bytes_q[1:0]] = data_byte_i;
        bytes_d              = bytes_q + 3'd1;
      end
      if (last_byte_i) begin
        if (full) begin
          burst_o.count                 = 3'd2;
          burst_o.words[1].end_of_frame = 1'b1;
          burst_o.words[1].frame_status = (crc_next != '0) ? crc32fa_pkg::StatusMismatch
                                                          : crc32fa_pkg::StatusGood;
        end else begin
          burst_o.count                 = 3'd1;
          burst_o.words[0].end_of_frame = 1'b1;
          if (bytes_q != 3'd3) begin
            burst_o.words[0].frame_status = crc32fa_pkg::StatusShort;
          end else begin
            burst_o.words[0].frame_status = (crc_next != '0) ? crc32fa_pkg::StatusMismatch
                                                            : crc32fa_pkg::StatusGood;
          end
        end
        crc_d   = '0;
        bytes_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q   <= '0;
      bytes_q <= '0;
    end else if (accept_i) begin
      crc_q   <= crc_d;
      bytes_q <= bytes_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      hold_q <= hold_d;
    end
  end

`ifndef SYNTHESIS
  a_bytes_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bytes_q <= 3'd4) else $error("holdback fill count out of range");
  a_frame_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && last_byte_i |=> bytes_q == '0 && crc_q == '0)
    else $error("frame end did not clear CRC state");
  a_full_stays: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && direction_i && !last_byte_i && full |=> bytes_q == 3'd4)
    else $error("full holdback line lost its fill");
`endif

endmodule

`default_nettype wire

/* sv/crc32fa_out_queue.sv */
// Result word queue: takes a burst per input word, emits one word per cycle while out_ready_i is high.
`default_nettype none

module crc32fa_out_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  load_i,
  input  crc32fa_pkg::burst_t   burst_i,
  output logic                  load_ready_o,
  output logic                  out_valid_o,
  output crc32fa_pkg::result_t  out_word_o,
  input  logic                  out_ready_i
);

  crc32fa_pkg::result_t slots_q [crc32fa_pkg::QueueDepth];
  crc32fa_pkg::result_t slots_d [crc32fa_pkg::QueueDepth];
  logic [2:0] count_q, count_d, count_left;
  logic       pop;

  assign out_valid_o  = (count_q != '0);
  assign out_word_o   = slots_q[0];
  assign load_ready_o = (count_q <= 3'd1);
  assign pop          = out_valid_o && out_ready_i;
  assign count_left   = count_q - {2'b00, pop};

  always_comb begin
    slots_d = slots_q;
    count_d = count_left;
    if (pop) begin
      for (int i = 0; i < crc32fa_pkg::QueueDepth - 1; i++) begin
        slots_d[i] = slots_q[i+1];
      end
    end
    if (load_i) begin
      // Append behind the word that is still waiting, if any.
      for (int j = 0; j < crc32fa_pkg::MaxBurst; j++) begin
        if (count_left[0]) begin
          slots_d[j+1] = burst_i.words[j];
        end else begin
          slots_d[j] = burst_i.words[j];
        end
      end
      count_d = count_left + burst_i.count;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slots_q <= slots_d;
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= 3'(crc32fa_pkg::QueueDepth)) else $error("queue overflow");
  a_load_only_when_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> count_q <= 3'd1) else $error("burst loaded without room");
  a_pop_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && !load_i |=> count_q == $past(count_q) - 3'd1)
    else $error("queue count did not drop on pop");
`endif

endmodule

`default_nettype wire

/* sv/crc32_frame_append_check.sv */
// Top level of the CRC-32 frame engine: append in transmit, check and strip in receive.
`default_nettype none

// Channel   Dir  Signals                          Payload
// s_axis    in   tvalid tready tdata[7:0] tlast   frame byte, tlast = last byte
// m_axis    out  tvalid tready tdata[7:0] tlast   out byte, tlast = end of frame,
//                tuser[2:0]                       tuser: has_data, frame_status
// cfg       in   cfg_valid_i cfg_ready_o          cfg_data_i[0] = direction
//
// One input word per cycle while s_axis_tready is high; the CRC update runs between the
// input handshake and the result queue. A transmit last word yields five result words, so
// the input stalls until at most one of them waits; a receive last word with a full line yields two.
// The input is taken while at most one result word waits, so one finished word
// may sit on m_axis while the next input is accepted.
// Reset clears the CRC, fill count, queue and direction (transmit). The holdback
// line is not reset; it is written before it is read in every frame.

module crc32_frame_append_check (
  input  logic       clk_i,
  input  logic       rst_ni,
  // Input stream; tdata: [7:0] data_byte. tlast: last_byte.
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,
  input  logic       s_axis_tlast,
  // Output stream; tdata: [7:0] out_byte. tlast: end_of_frame.
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,
  output logic       m_axis_tlast,
  // tuser: [0] has_data, [2:1] frame_status.
  output logic [2:0] m_axis_tuser,
  // Direction register write: 0 transmit/append, 1 receive/check.
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic       cfg_data_i
);

  logic                 direction_q;
  logic                 in_accept;
  crc32fa_pkg::burst_t  burst;
  crc32fa_pkg::result_t out_word;

  // Configuration must only be written while idle; the block does not enforce this and always takes it.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      direction_q <= 1'b0;
    end else if (cfg_valid_i) begin
      direction_q <= cfg_data_i;
    end
  end

  assign in_accept = s_axis_tvalid && s_axis_tready;

  // Advance the CRC and build this word's results.
  crc32fa_crc_unit u_crc (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (in_accept),
    .data_byte_i (s_axis_tdata),
    .last_byte_i (s_axis_tlast),
    .direction_i (direction_q),
    .burst_o     (burst)
  );

  // Hold the results and hand them out one per cycle while m_axis_tready is high.
  crc32fa_out_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (in_accept),
    .burst_i      (burst),
    .load_ready_o (s_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_word_o   (out_word),
    .out_ready_i  (m_axis_tready)
  );

  assign m_axis_tdata = out_word.out_byte;
  assign m_axis_tlast = out_word.end_of_frame;
  assign m_axis_tuser = {out_word.frame_status, out_word.has_data};

endmodule

`default_nettype wire
